/* rtl/core/gpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gpd_pkg
// Types and constants for the RGB pyramid reduce stage.
// ----------------------------------------------------------------------------
package gpd_pkg;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam int          IMAGE_WIDTH_RESET  = 640;
  localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;
  localparam int          MIN_DIM            = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Vertical sum of one column, per channel
  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } vcol_t;

  // Row mirroring at the top and bottom of the frame
  typedef enum logic [1:0] {
    V_NORM = 2'd0,
    V_TOP  = 2'd1,
    V_BOT2 = 2'd2,
    V_BOT1 = 2'd3
  } vcase_t;

  // Column mirroring at the left and right edge
  typedef enum logic [1:0] {
    H_NORM  = 2'd0,
    H_LEFT  = 2'd1,
    H_REVEN = 2'd2,
    H_RODD  = 2'd3
  } hcase_t;

  // Per-item control: which centers leave and where they sit
  typedef struct packed {
    logic        na;
    logic        nb;
    hcase_t      hcase_a;
    logic [14:0] row;
    logic [9:0]  col_a;
    logic [9:0]  col_b;
    logic        fe_a;
    logic        fe_b;
  } ctl_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] row;
    logic [9:0]  col;
    logic        frame_end;
    logic        run_last;
  } res_t;

  // 1-4-6-4-1 taps on 8-bit samples
  function automatic logic [11:0] vfilt(input logic [7:0] t0, input logic [7:0] t1,
                                        input logic [7:0] t2, input logic [7:0] t3,
                                        input logic [7:0] t4);
    logic [11:0] outer;
    logic [11:0] inner;
    logic [11:0] mid;
    outer = {4'd0, t0} + {4'd0, t4};
    inner = ({4'd0, t1} + {4'd0, t3}) << 2;
    mid   = {4'd0, t2} * 12'd6;
    return outer + inner + mid;
  endfunction

  // 1-4-6-4-1 taps on column sums, rounded and scaled by 1/256
  function automatic logic [7:0] hfilt(input logic [11:0] t0, input logic [11:0] t1,
                                       input logic [11:0] t2, input logic [11:0] t3,
                                       input logic [11:0] t4);
    logic [15:0] acc;
    acc = ({4'd0, t0} + {4'd0, t4}) + (({4'd0, t1} + {4'd0, t3}) << 2)
        + ({4'd0, t2} * 16'd6) + 16'd128;
    return acc[15:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/gaussian_pyramid_downsample.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_pyramid_downsample
// One reduce level: 5x5 binomial smoothing of RGB with mirrored borders,
// then keep even rows and even columns.
// ----------------------------------------------------------------------------
// Path: an item passes stage 0, stage 1 and the output register before its result shows.
// Throughput: one item per cycle while the output register can take results; the item
//   at the last column of a row can cause two results, which the output register delivers in turn.
// Reset (rst, synchronous): clears the frame position, the pipeline and the
//   output register, and loads width 640 and height 480. Line stores are not
//   cleared; every row that is read was written earlier in the same frame.
module gaussian_pyramid_downsample #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic        s_tuser,    // action: 0 pixel, 1 drain tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // red_out, green_out, blue_out, out_row[38:24],
                                  // out_col[48:39], zero fill
  output logic        m_tlast,    // frame_end
  output logic        m_tuser,    // run_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import gpd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int W_RST = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;

  // Effective (clamped) frame size
  logic [WW-1:0]    eff_w;
  logic [15:0]      eff_h;
  logic [WW-1:0]    cfg_w_next;
  logic [15:0]      cfg_h_next;

  // Frame position
  logic [15:0]      row;
  logic [COL_W-1:0] col;
  logic             half;      // second drain row

  // Item decode
  logic             drain, real_px, skip, at_last, xe, emit_row, x_ok, fe_row, accept;
  logic [COL_W-1:0] last_col, fe_col, c_a;
  logic [16:0]      y, cr, h_ext;
  ctl_t             ctl_in;
  vcase_t           vcase_in;
  rgb_t             pix_in;

  // Stage 0: registered item and line store read
  logic             s0_valid;
  rgb_t             s0_pix;
  logic [1:0]       s0_base;
  vcase_t           s0_vcase;
  ctl_t             s0_ctl;
  logic [23:0]      line_rd [4];

  // Stage 1: column sums and control
  logic             s1_valid;
  ctl_t             s1_ctl;
  vcol_t            sh [5];
  vcol_t            vnew;
  rgb_t             k0, k1, k2, k3, t0, t1, t2, t3, t4;

  // Output register, up to two results
  res_t             out_buf0, out_buf1, res_a, res_b;
  logic [1:0]       out_cnt;
  logic             adv, out_free, load, pop;

  // --------------------------------------------------------------------------
  // Configuration: clamp on write, restart the frame
  // --------------------------------------------------------------------------
  always_comb begin
    if (int'(cfg_data[11:0]) > MAX_WIDTH) begin
      cfg_w_next = WW'(MAX_WIDTH);
    end else if (int'(cfg_data[11:0]) < MIN_DIM) begin
      cfg_w_next = WW'(MIN_DIM);
    end else begin
      cfg_w_next = WW'(cfg_data[11:0]);
    end
    if (int'(cfg_data) < MIN_DIM) begin
      cfg_h_next = 16'(MIN_DIM);
    end else begin
      cfg_h_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= WW'(W_RST);
      eff_h <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  eff_w <= cfg_w_next;
        CFG_IMAGE_HEIGHT: eff_h <= cfg_h_next;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Item decode. A center (cr, c) leaves when column c+2 of row cr+2 arrives; the last
  // column of a row also closes the centers in the last two columns, which no column c+2 reaches.
  // --------------------------------------------------------------------------
  always_comb begin
    accept   = s_tvalid && s_tready;
    drain    = row >= eff_h;
    real_px  = !drain && !s_tuser;
    skip     = !drain && s_tuser;     // drain tick inside a frame: drop
    last_col = COL_W'(eff_w - WW'(1));
    at_last  = col == last_col;
    h_ext    = {1'b0, eff_h};
    y        = drain ? (h_ext + 17'(half)) : {1'b0, row};
    cr       = y - 17'd2;
    emit_row = (y >= 17'd2) && !y[0];
    x_ok     = col >= COL_W'(2);
    xe       = !col[0];
    c_a      = xe ? (col - COL_W'(2)) : (col - COL_W'(1));
    fe_row   = cr == ((h_ext - 17'd1) & ~17'd1);
    fe_col   = last_col & ~COL_W'(1);

    ctl_in.na      = emit_row && x_ok && (xe || at_last);
    ctl_in.nb      = emit_row && x_ok && xe && at_last;
    ctl_in.hcase_a = !xe ? H_REVEN : ((col == COL_W'(2)) ? H_LEFT : H_NORM);
    ctl_in.row     = cr[15:1];
    ctl_in.col_a   = 10'(c_a >> 1);
    ctl_in.col_b   = 10'(col >> 1);
    ctl_in.fe_a    = fe_row && (c_a == fe_col);
    ctl_in.fe_b    = fe_row && (col == fe_col);

    if (y == 17'd2) begin
      vcase_in = V_TOP;
    end else if (y == h_ext) begin
      vcase_in = V_BOT2;
    end else if (y == h_ext + 17'd1) begin
      vcase_in = V_BOT1;
    end else begin
      vcase_in = V_NORM;
    end

    pix_in.red   = s_tdata[7:0];
    pix_in.green = s_tdata[15:8];
    pix_in.blue  = s_tdata[23:16];
  end

  // Frame position: advance per pixel, then two drain rows, then restart
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row  <= '0;
      col  <= '0;
      half <= 1'b0;
    end else if (accept && !skip) begin
      if (!at_last) begin
        col <= col + COL_W'(1);
      end else begin
        col <= '0;
        if (real_px) begin
          row <= row + 16'd1;
        end else if (half) begin
          row  <= '0;
          half <= 1'b0;
        end else begin
          half <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Four line stores; row r lives in store r mod 4. Read before write: the
  // row four back is still read at this column before the new pixel lands.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < 4; g++) begin : g_line
    logic [23:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (accept && real_px && (y[1:0] == 2'(g))) begin
        mem[col] <= pix_in;
      end
      if (accept) begin
        line_rd[g] <= mem[col];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: hold everything while results cannot enter the output
  // --------------------------------------------------------------------------
  always_comb begin
    pop      = m_tvalid && m_tready;
    out_free = (out_cnt == 2'd0) || ((out_cnt == 2'd1) && m_tready);
    adv      = !(s1_valid && s1_ctl.na) || out_free;
    load     = adv && s1_valid && s1_ctl.na;
    s_tready = adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= accept && !skip;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pix   <= pix_in;
      s0_base  <= y[1:0];
      s0_vcase <= vcase_in;
      s0_ctl   <= ctl_in;
    end
  end

  // --------------------------------------------------------------------------
  // Vertical pass. k0..k3 are rows y-4..y-1, the live pixel is row y.
  // --------------------------------------------------------------------------
  function automatic rgb_t pick(input logic [1:0] idx, input logic [23:0] a,
                                input logic [23:0] b, input logic [23:0] c,
                                input logic [23:0] d);
    rgb_t sel;
    unique case (idx)
      2'd0: sel = a;
      2'd1: sel = b;
      2'd2: sel = c;
      2'd3: sel = d;
    endcase
    return sel;
  endfunction

  always_comb begin
    k0 = pick(s0_base,         line_rd[0], line_rd[1], line_rd[2], line_rd[3]);
    k1 = pick(s0_base + 2'd1,  line_rd[0], line_rd[1], line_rd[2], line_rd[3]);
    k2 = pick(s0_base + 2'd2,  line_rd[0], line_rd[1], line_rd[2], line_rd[3]);
    k3 = pick(s0_base + 2'd3,  line_rd[0], line_rd[1], line_rd[2], line_rd[3]);
    unique case (s0_vcase)
      V_NORM: begin t0 = k0;     t1 = k1; t2 = k2; t3 = k3; t4 = s0_pix; end
      V_TOP:  begin t0 = s0_pix; t1 = k3; t2 = k2; t3 = k3; t4 = s0_pix; end
      V_BOT2: begin t0 = k0;     t1 = k1; t2 = k2; t3 = k3; t4 = k2;     end
      V_BOT1: begin t0 = k0;     t1 = k1; t2 = k2; t3 = k1; t4 = k0;     end
    endcase
    vnew.red   = vfilt(t0.red,   t1.red,   t2.red,   t3.red,   t4.red);
    vnew.green = vfilt(t0.green, t1.green, t2.green, t3.green, t4.green);
    vnew.blue  = vfilt(t0.blue,  t1.blue,  t2.blue,  t3.blue,  t4.blue);
  end

  // Column line: sh[0] is the newest column, sh[4] four columns back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s0_valid) begin
      sh[0]  <= vnew;
      sh[1]  <= sh[0];
      sh[2]  <= sh[1];
      sh[3]  <= sh[2];
      sh[4]  <= sh[3];
      s1_ctl <= s0_ctl;
    end
  end

  // --------------------------------------------------------------------------
  // Horizontal pass with mirrored columns at both edges
  // --------------------------------------------------------------------------
  function automatic rgb_t hpass(input hcase_t hc, input vcol_t a0, input vcol_t a1,
                                 input vcol_t a2, input vcol_t a3, input vcol_t a4);
    vcol_t u0, u1, u2, u3, u4;
    rgb_t  o;
    unique case (hc)
      H_NORM:  begin u0 = a4; u1 = a3; u2 = a2; u3 = a1; u4 = a0; end
      H_LEFT:  begin u0 = a0; u1 = a1; u2 = a2; u3 = a1; u4 = a0; end
      H_REVEN: begin u0 = a3; u1 = a2; u2 = a1; u3 = a0; u4 = a1; end
      H_RODD:  begin u0 = a2; u1 = a1; u2 = a0; u3 = a1; u4 = a2; end
    endcase
    o.red   = hfilt(u0.red,   u1.red,   u2.red,   u3.red,   u4.red);
    o.green = hfilt(u0.green, u1.green, u2.green, u3.green, u4.green);
    o.blue  = hfilt(u0.blue,  u1.blue,  u2.blue,  u3.blue,  u4.blue);
    return o;
  endfunction

  rgb_t pa, pb;

  always_comb begin
    pa = hpass(s1_ctl.hcase_a, sh[0], sh[1], sh[2], sh[3], sh[4]);
    pb = hpass(H_RODD,         sh[0], sh[1], sh[2], sh[3], sh[4]);

    res_a.red       = pa.red;
    res_a.green     = pa.green;
    res_a.blue      = pa.blue;
    res_a.row       = s1_ctl.row;
    res_a.col       = s1_ctl.col_a;
    res_a.frame_end = s1_ctl.fe_a;
    res_a.run_last  = !s1_ctl.nb;

    res_b.red       = pb.red;
    res_b.green     = pb.green;
    res_b.blue      = pb.blue;
    res_b.row       = s1_ctl.row;
    res_b.col       = s1_ctl.col_b;
    res_b.frame_end = s1_ctl.fe_b;
    res_b.run_last  = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Output register: load one result or a pair, or advance the second into the first on pop
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (load) begin
      out_cnt <= s1_ctl.nb ? 2'd2 : 2'd1;
    end else if (pop) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_buf0 <= res_a;
      out_buf1 <= res_b;
    end else if (pop) begin
      out_buf0 <= out_buf1;
    end
  end

  assign m_tvalid = out_cnt != 2'd0;
  assign m_tdata  = {7'd0, out_buf0.col, out_buf0.row,
                     out_buf0.blue, out_buf0.green, out_buf0.red};
  assign m_tlast  = out_buf0.frame_end;
  assign m_tuser  = out_buf0.run_last;

`ifndef SYNTHESIS
  a_pair_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_cnt == 2'd2) |-> !out_buf0.run_last)
    else $error("first of a result pair marked as last");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> ((out_cnt == 2'd0) || ((out_cnt == 2'd1) && m_tready)))
    else $error("output register overwritten before delivery");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= eff_h)
    else $error("row counter past frame height");

  a_half_in_drain: assert property (@(posedge clk) disable iff (rst)
    half |-> (row >= eff_h))
    else $error("drain row flag set inside a frame");

  a_pair_implies_first: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ctl.nb) |-> s1_ctl.na)
    else $error("second result without a first");
`endif

endmodule
`default_nettype wire
